// ===== hdl/twc_pkg.sv =====
package twc_pkg;

  // Fixed geometry of the cache and the address space.
  localparam int TAG_BITS_DEF = 6;
  localparam int SETS         = 32;
  localparam int LINE_SIZE    = 32;
  localparam int WAYS         = 2;
  localparam int ADDR_BITS    = 16;
  localparam int DATA_BITS    = 8;
  localparam int CNT_BITS     = 32;
  localparam int SET_BITS     = $clog2(SETS);
  localparam int OFF_BITS     = $clog2(LINE_SIZE);
  localparam int TAG_LSB      = SET_BITS + OFF_BITS;
  localparam int XFER_BITS    = OFF_BITS + 1;
  localparam int DMEM_BITS    = 1 + SET_BITS + OFF_BITS;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_WBACK,
    ST_FILL,
    ST_ACCESS,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_rdy;
    logic clr_step;
    logic lookup;
    logic wb_step;
    logic fill_step;
    logic access;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic hit;
    logic need_wb;
    logic xfer_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/twc_if.sv =====
interface twc_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [twc_pkg::ADDR_BITS-1:0] address;
  logic [twc_pkg::DATA_BITS-1:0] write_data;

  modport source (output valid, req_type, address, write_data, input ready);
  modport sink (input valid, req_type, address, write_data, output ready);
endinterface

interface twc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [twc_pkg::DATA_BITS-1:0] read_data;
  logic                          wrote_back;
  logic [twc_pkg::CNT_BITS-1:0]  hit_count;
  logic [twc_pkg::CNT_BITS-1:0]  miss_count;

  modport source (output valid, hit, read_data, wrote_back, hit_count, miss_count,
                  input ready);
  modport sink (input valid, hit, read_data, wrote_back, hit_count, miss_count,
                output ready);
endinterface

// ===== hdl/twc_ctrl.sv =====
module twc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  twc_pkg::sts_t  sts,
  output twc_pkg::cmd_t  cmd,
  output twc_pkg::state_t state
);

  twc_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= twc_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      twc_pkg::ST_CLEAR:  if (sts.clr_done) state_nxt = twc_pkg::ST_IDLE;
      twc_pkg::ST_IDLE:   if (in_valid) state_nxt = twc_pkg::ST_LOOKUP;
      twc_pkg::ST_LOOKUP: begin
        if (sts.hit) state_nxt = twc_pkg::ST_ACCESS;
        else if (sts.need_wb) state_nxt = twc_pkg::ST_WBACK;
        else state_nxt = twc_pkg::ST_FILL;
      end
      twc_pkg::ST_WBACK:  if (sts.xfer_last) state_nxt = twc_pkg::ST_FILL;
      twc_pkg::ST_FILL:   if (sts.xfer_last) state_nxt = twc_pkg::ST_ACCESS;
      twc_pkg::ST_ACCESS: state_nxt = twc_pkg::ST_RESP;
      twc_pkg::ST_RESP:   if (sts.out_free) state_nxt = twc_pkg::ST_IDLE;
      default:            state_nxt = twc_pkg::ST_CLEAR;
    endcase
  end

  // Commands decoded from the state.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      twc_pkg::ST_CLEAR:  cmd.clr_step = 1'b1;
      twc_pkg::ST_IDLE:   cmd.in_rdy = 1'b1;
      twc_pkg::ST_LOOKUP: cmd.lookup = 1'b1;
      twc_pkg::ST_WBACK:  cmd.wb_step = 1'b1;
      twc_pkg::ST_FILL:   cmd.fill_step = 1'b1;
      twc_pkg::ST_ACCESS: cmd.access = 1'b1;
      twc_pkg::ST_RESP:   cmd.out_load = sts.out_free;
      default:            cmd = '0;
    endcase
  end

  assign state = state_r;

endmodule

// ===== hdl/twc_dp.sv =====
module twc_dp #(
  parameter int TAG_BITS = twc_pkg::TAG_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  twc_pkg::cmd_t cmd,
  output twc_pkg::sts_t sts,
  twc_req_if.sink       in_ch,
  twc_rsp_if.source     out_ch
);

  localparam int SB = twc_pkg::SET_BITS;
  localparam int OB = twc_pkg::OFF_BITS;
  localparam int XB = twc_pkg::XFER_BITS;

  // Memories: tags per way, cache data and the backing store.
  logic [TAG_BITS-1:0]           tag0_mem [twc_pkg::SETS];
  logic [TAG_BITS-1:0]           tag1_mem [twc_pkg::SETS];
  logic [twc_pkg::DATA_BITS-1:0] dmem [2**twc_pkg::DMEM_BITS];
  logic [twc_pkg::DATA_BITS-1:0] bmem [2**twc_pkg::ADDR_BITS];

  logic [TAG_BITS-1:0]           tag0_q, tag1_q;
  logic [twc_pkg::DATA_BITS-1:0] dmem_q, bmem_q;

  // Request and control registers.
  logic                          type_r;
  logic [twc_pkg::ADDR_BITS-1:0] addr_r;
  logic [twc_pkg::DATA_BITS-1:0] wdata_r;
  logic [twc_pkg::WAYS-1:0][twc_pkg::SETS-1:0] valid_r, dirty_r;
  logic [twc_pkg::ADDR_BITS-1:0] clr_cnt_r;
  logic [XB-1:0]                 xfer_r;
  logic [15:0]                   lfsr_r;
  logic                          way_r, hit_r, wb_r;
  logic [TAG_BITS-1:0]           vtag_r;
  logic [twc_pkg::CNT_BITS-1:0]  hits_r, misses_r;
  logic                          out_valid_r;

  logic [SB-1:0]       set_r;
  logic [OB-1:0]       off_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [SB-1:0]       in_set;
  logic                v0, v1, h0, h1, hit, miss_way, need_wb, lfsr_step;
  logic [15:0]         lfsr_nxt;
  logic [OB-1:0]       xoff, xoff_prev;
  logic [twc_pkg::ADDR_BITS-1:0] wb_base;
  logic                req_take, xfer_last;

  assign set_r   = addr_r[twc_pkg::TAG_LSB-1:OB];
  assign off_r   = addr_r[OB-1:0];
  assign tag_r   = TAG_BITS'(addr_r >> twc_pkg::TAG_LSB);
  assign in_set  = in_ch.address[twc_pkg::TAG_LSB-1:OB];
  assign req_take = cmd.in_rdy && in_ch.valid;
  assign in_ch.ready = cmd.in_rdy;

  // Tag compare and victim choice.
  assign v0 = valid_r[0][set_r];
  assign v1 = valid_r[1][set_r];
  assign h0 = v0 && (tag0_q == tag_r);
  assign h1 = v1 && (tag1_q == tag_r);
  assign hit = h0 || h1;
  assign lfsr_nxt = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[15:1]};
  assign lfsr_step = !hit && v0 && v1;
  assign miss_way = !v0 ? 1'b0 : (!v1 ? 1'b1 : lfsr_nxt[0]);
  assign need_wb = valid_r[miss_way][set_r] && dirty_r[miss_way][set_r];

  // Line transfer counter runs one beat ahead of the write side.
  assign xfer_last = (xfer_r == XB'(twc_pkg::LINE_SIZE));
  assign xoff      = xfer_r[OB-1:0];
  assign xoff_prev = OB'(xfer_r - XB'(1));
  assign wb_base   = twc_pkg::ADDR_BITS'(32'(vtag_r) << twc_pkg::TAG_LSB)
                   | {{(twc_pkg::ADDR_BITS-SB-OB){1'b0}}, set_r, {OB{1'b0}}};

  assign sts.clr_done  = &clr_cnt_r;
  assign sts.hit       = hit;
  assign sts.need_wb   = need_wb;
  assign sts.xfer_last = xfer_last;
  assign sts.out_free  = !out_valid_r || out_ch.ready;

  // Request capture, tag read, lookup registers and tag update.
  always_ff @(posedge clk) begin
    if (req_take) begin
      type_r  <= in_ch.req_type;
      addr_r  <= in_ch.address;
      wdata_r <= in_ch.write_data;
      tag0_q  <= tag0_mem[in_set];
      tag1_q  <= tag1_mem[in_set];
    end
    if (cmd.lookup) begin
      way_r  <= hit ? h1 : miss_way;
      hit_r  <= hit;
      wb_r   <= !hit && need_wb;
      vtag_r <= miss_way ? tag1_q : tag0_q;
    end
    if (cmd.fill_step && xfer_last) begin
      if (way_r) tag1_mem[set_r] <= tag_r;
      else tag0_mem[set_r] <= tag_r;
    end
  end

  // Cache data memory: one read and one write port.
  always_ff @(posedge clk) begin
    if (cmd.wb_step && !xfer_last) begin
      dmem_q <= dmem[{way_r, set_r, xoff}];
    end else if (cmd.access && type_r == twc_pkg::REQ_READ) begin
      dmem_q <= dmem[{way_r, set_r, off_r}];
    end
    if (cmd.fill_step && xfer_r != '0) begin
      dmem[{way_r, set_r, xoff_prev}] <= bmem_q;
    end else if (cmd.access && type_r == twc_pkg::REQ_WRITE) begin
      dmem[{way_r, set_r, off_r}] <= wdata_r;
    end
  end

  // Backing memory: clearing pass, write-back and fill.
  always_ff @(posedge clk) begin
    if (cmd.fill_step && !xfer_last) begin
      bmem_q <= bmem[{addr_r[twc_pkg::ADDR_BITS-1:OB], xoff}];
    end
    if (cmd.clr_step) begin
      bmem[clr_cnt_r] <= '0;
    end else if (cmd.wb_step && xfer_r != '0) begin
      bmem[wb_base | {{(twc_pkg::ADDR_BITS-OB){1'b0}}, xoff_prev}] <= dmem_q;
    end
  end

  // Control state: counters, flags and the LFSR.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      dirty_r     <= '0;
      clr_cnt_r   <= '0;
      xfer_r      <= '0;
      lfsr_r      <= twc_pkg::LFSR_SEED;
      hits_r      <= '0;
      misses_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.wb_step || cmd.fill_step) begin
        xfer_r <= xfer_last ? '0 : xfer_r + 1'b1;
      end
      if (cmd.lookup) begin
        if (hit) hits_r <= hits_r + 1'b1;
        else misses_r <= misses_r + 1'b1;
        if (lfsr_step) lfsr_r <= lfsr_nxt;
      end
      if (cmd.fill_step && xfer_last) begin
        valid_r[way_r][set_r] <= 1'b1;
        dirty_r[way_r][set_r] <= 1'b0;
      end
      if (cmd.access && type_r == twc_pkg::REQ_WRITE) begin
        dirty_r[way_r][set_r] <= 1'b1;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.hit        <= hit_r;
      out_ch.read_data  <= (type_r == twc_pkg::REQ_WRITE) ? '0 : dmem_q;
      out_ch.wrote_back <= wb_r;
      out_ch.hit_count  <= hits_r;
      out_ch.miss_count <= misses_r;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

// ===== hdl/two_way_write_back_cache.sv =====
// Sequence: a hit goes from the lookup to the access and then to the result; a
// miss first fills the line from the backing memory, after writing back a dirty victim.
// One request at a time; a line transfer moves one byte at a time over the
// byte-wide ports of the cache data and backing memories.
// Reset: synchronous, active low; after reset a clearing pass zeroes the backing
// memory, during which no request is taken.
module two_way_write_back_cache #(
  parameter int TAG_BITS = twc_pkg::TAG_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  twc_req_if.sink   in_ch,
  twc_rsp_if.source out_ch
);

  twc_pkg::cmd_t   cmd;
  twc_pkg::sts_t   sts;
  twc_pkg::state_t state;

  twc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  twc_dp #(.TAG_BITS(TAG_BITS)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // A result is only loaded when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free) else $error("result overwrote a pending one");

  // Only one request is in flight.
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("second request taken");

  // A finished write-back is always followed by a fill.
  a_wb_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wb_step && sts.xfer_last) |=> cmd.fill_step) else $error("write-back not followed by fill");

  // At most one datapath operation per cycle.
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.in_rdy, cmd.clr_step, cmd.lookup, cmd.wb_step, cmd.fill_step,
              cmd.access, cmd.out_load})) else $error("conflicting commands");

  // No request is taken during the clearing pass.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state == twc_pkg::ST_CLEAR) |-> !in_ch.ready) else $error("request taken while clearing");

endmodule
